// ----- hdl/bpa_pkg.sv -----
// Package for the bitmap page allocator: mode, status and register codes,
// default sizes and the command/status structs between controller and datapath.
// No dependencies.
package bpa_pkg;

    localparam int PAGE_BITS_DEF = 12;
    localparam int WORD_BITS_DEF = 64;
    localparam int MAX_PAGES_DEF = 4096;

    localparam int ADDR_W  = 48;
    localparam int COUNT_W = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [2:0] MODE_ALLOC    = 3'd0;
    localparam logic [2:0] MODE_FREE     = 3'd1;
    localparam logic [2:0] MODE_RESERVE  = 3'd2;
    localparam logic [2:0] MODE_QUERY    = 3'd3;
    localparam logic [2:0] MODE_RFREE    = 3'd4;
    localparam logic [2:0] MODE_RRESERVE = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMEM   = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES = 2'd1;

    localparam logic [COUNT_W-1:0] PAGES_RESET = 13'd4096;

    typedef struct packed {
        logic start;
        logic loc;
        logic rd;
        logic ex;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic mode_alloc;
        logic mode_single;
        logic mode_range;
        logic loc_ok;
        logic count_zero;
        logic range_go;
        logic next_rd;
        logic next_rchk;
        logic out_free;
    } t_stat;

endpackage

// ----- hdl/bitmap_page_allocator_core.sv -----
// Bitmap physical page allocator: one bit per page of a single region, held in a
// word-wide RAM with registered read data. An item is taken in, its address is
// located, and the work below is done before it finishes: alloc reads bitmap
// words from the top of the region down until it finds a free page or passes the
// bottom word, free and reserve read and update their one word and query only
// reads it, and the range modes walk the range page by page, updating each page's
// word. Each word goes through the RAM's single read-modify-write path. The bitmap
// needs no clearing pass: per-word valid bits, cleared at reset and on a
// region_pages write, make unwritten words read as free.
// Configuration is always ready and is meant to be written while idle.
// Depends on bpa_pkg, bpa_ctrl, bpa_dpath and bpa_ram.
module bitmap_page_allocator_core #(
    parameter int PAGE_BITS = bpa_pkg::PAGE_BITS_DEF,
    parameter int WORD_BITS = bpa_pkg::WORD_BITS_DEF,
    parameter int MAX_PAGES = bpa_pkg::MAX_PAGES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [2:0]                      i_mode,
    input  logic [bpa_pkg::ADDR_W-1:0]      i_address,
    input  logic [bpa_pkg::ADDR_W-1:0]      i_end_address,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [1:0]                      o_status,
    output logic [bpa_pkg::ADDR_W-1:0]      o_granted_address,
    output logic                            o_page_was_taken,
    output logic [bpa_pkg::COUNT_W-1:0]     o_free_pages,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bpa_pkg::ADDR_W-1:0]      i_cfg_data
);
    bpa_pkg::t_cmd  cmd;
    bpa_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    bpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    bpa_dpath #(
        .PAGE_BITS (PAGE_BITS),
        .WORD_BITS (WORD_BITS),
        .MAX_PAGES (MAX_PAGES)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_mode            (i_mode),
        .i_address         (i_address),
        .i_end_address     (i_end_address),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_granted_address (o_granted_address),
        .o_page_was_taken  (o_page_was_taken),
        .o_free_pages      (o_free_pages)
    );

`ifndef SYNTH
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.start, cmd.loc, cmd.rd, cmd.ex, cmd.fin}))
        else $error("more than one datapath command at once");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready stayed high after an item was taken");

    a_nomem_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != bpa_pkg::ST_OK) |-> (o_granted_address == '0))
        else $error("address granted on a failed item");
`endif
endmodule

// ----- hdl/bpa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/bpa_ctrl.sv -----
// Controller state machine of the page allocator.
// Depends on bpa_pkg (command and status structs).
module bpa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  bpa_pkg::t_stat i_stat,
    output bpa_pkg::t_cmd  o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOC  = 3'd1;
    localparam logic [2:0] S_RCHK = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_EX   = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_LOC;
                end
            end
            S_LOC: begin
                o_cmd.loc = 1'b1;
                if (i_stat.mode_alloc) begin
                    n_state = i_stat.count_zero ? S_FIN : S_RD;
                end else if (i_stat.mode_single && i_stat.loc_ok) begin
                    n_state = S_RD;
                end else if (i_stat.mode_range && i_stat.loc_ok) begin
                    n_state = S_RCHK;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_RCHK: begin
                n_state = i_stat.range_go ? S_RD : S_FIN;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EX;
            end
            S_EX: begin
                o_cmd.ex = 1'b1;
                if (i_stat.next_rd) begin
                    n_state = S_RD;
                end else if (i_stat.next_rchk) begin
                    n_state = S_RCHK;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold until the output register can take the item
                if (i_stat.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);
endmodule

// ----- hdl/bpa_dpath.sv -----
// Datapath of the page allocator: region registers, free count, bitmap RAM
// with per-word valid bits, scan and range walk, output register.
// Depends on bpa_pkg and bpa_ram.
module bpa_dpath #(
    parameter int PAGE_BITS = bpa_pkg::PAGE_BITS_DEF,
    parameter int WORD_BITS = bpa_pkg::WORD_BITS_DEF,
    parameter int MAX_PAGES = bpa_pkg::MAX_PAGES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bpa_pkg::t_cmd                   i_cmd,
    output bpa_pkg::t_stat                  o_stat,
    input  logic [2:0]                      i_mode,
    input  logic [bpa_pkg::ADDR_W-1:0]      i_address,
    input  logic [bpa_pkg::ADDR_W-1:0]      i_end_address,
    input  logic                            i_cfg_valid,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bpa_pkg::ADDR_W-1:0]      i_cfg_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [1:0]                      o_status,
    output logic [bpa_pkg::ADDR_W-1:0]      o_granted_address,
    output logic                            o_page_was_taken,
    output logic [bpa_pkg::COUNT_W-1:0]     o_free_pages
);
    localparam int AW        = bpa_pkg::ADDR_W;
    localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CW        = $clog2(MAX_PAGES + 1);
    localparam int BW        = $clog2(WORD_BITS);

    logic [AW-1:0]                  r_base;
    logic [bpa_pkg::COUNT_W-1:0]    r_pages;
    logic [CW-1:0]                  r_count;
    logic [MAP_WORDS-1:0]           r_row_valid;
    logic [2:0]                     r_mode;
    logic [AW:0]                    r_addr;
    logic [AW-1:0]                  r_end;
    logic [CW-1:0]                  r_page;
    logic [WW-1:0]                  r_word;
    logic [WW-1:0]                  r_rd_word;
    logic [1:0]                     r_status;
    logic [AW-1:0]                  r_granted;
    logic                           r_taken;
    logic                           r_out_valid;
    logic [1:0]                     r_o_status;
    logic [AW-1:0]                  r_o_granted;
    logic                           r_o_taken;
    logic [bpa_pkg::COUNT_W-1:0]    r_o_free;

    logic [CW-1:0]        eff;
    logic [CW-1:0]        cfg_eff;
    logic                 addr_ge;
    logic [AW-1:0]        addr_diff;
    logic [AW-1:0]        addr_off;
    logic                 loc_ok;
    logic [CW-1:0]        eff_m1;
    logic [WW-1:0]        top_word;
    logic [CW-1:0]        top_rem;
    logic [WW-1:0]        pg_word;
    logic [BW-1:0]        pg_bit;
    logic [WW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] word;
    logic                 found;
    logic [BW-1:0]        fbit;
    logic [CW-1:0]        found_page;
    logic                 was;
    logic                 take;
    logic                 is_alloc;
    logic                 is_single;
    logic                 is_range;
    logic                 ram_we;
    logic [WW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 out_free;

    // effective page count: register clipped to the bitmap size
    always_comb begin
        if (32'(r_pages) > 32'(MAX_PAGES)) begin
            eff = CW'(MAX_PAGES);
        end else begin
            eff = CW'(r_pages);
        end
        if (32'(i_cfg_data[bpa_pkg::COUNT_W-1:0]) > 32'(MAX_PAGES)) begin
            cfg_eff = CW'(MAX_PAGES);
        end else begin
            cfg_eff = CW'(i_cfg_data[bpa_pkg::COUNT_W-1:0]);
        end
    end

    assign addr_ge   = (r_addr[AW-1:0] >= r_base);
    assign addr_diff = r_addr[AW-1:0] - r_base;
    assign addr_off  = addr_diff >> PAGE_BITS;
    assign loc_ok    = addr_ge && (addr_off < AW'(eff));

    assign eff_m1   = eff - CW'(1);
    assign top_word = WW'(eff_m1 / WORD_BITS);
    assign top_rem  = eff - CW'(32'(top_word) * WORD_BITS);

    assign pg_word = WW'(r_page / WORD_BITS);
    assign pg_bit  = BW'(r_page % WORD_BITS);

    assign is_alloc  = (r_mode == bpa_pkg::MODE_ALLOC);
    assign is_single = (r_mode == bpa_pkg::MODE_FREE) || (r_mode == bpa_pkg::MODE_RESERVE)
                    || (r_mode == bpa_pkg::MODE_QUERY);
    assign is_range  = (r_mode == bpa_pkg::MODE_RFREE) || (r_mode == bpa_pkg::MODE_RRESERVE);
    assign take      = (r_mode == bpa_pkg::MODE_RESERVE) || (r_mode == bpa_pkg::MODE_RRESERVE);

    assign ram_raddr = is_alloc ? r_word : pg_word;

    bpa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // a word never written since the last clear reads as all free
    assign word = r_row_valid[r_rd_word] ? ram_rdata : '0;
    assign was  = word[pg_bit];

    // highest clear bit of the word, limited to pages inside the region
    always_comb begin
        found = 1'b0;
        fbit  = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (!word[b] && ((r_rd_word != top_word) || (CW'(b) < top_rem))) begin
                found = 1'b1;
                fbit  = BW'(b);
            end
        end
    end

    assign found_page = CW'(32'(r_rd_word) * WORD_BITS + 32'(fbit));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_rd_word;
        ram_wdata = word;
        if (i_cmd.ex) begin
            if (is_alloc) begin
                ram_we    = found;
                ram_wdata = word | (WORD_BITS'(1) << fbit);
            end else if (r_mode != bpa_pkg::MODE_QUERY && was != take) begin
                ram_we = 1'b1;
                if (take) begin
                    ram_wdata = word | (WORD_BITS'(1) << pg_bit);
                end else begin
                    ram_wdata = word & ~(WORD_BITS'(1) << pg_bit);
                end
            end
        end
    end

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        o_stat             = '0;
        o_stat.mode_alloc  = is_alloc;
        o_stat.mode_single = is_single;
        o_stat.mode_range  = is_range;
        o_stat.loc_ok      = loc_ok;
        o_stat.count_zero  = (r_count == '0);
        o_stat.range_go    = (r_addr < {1'b0, r_end}) && (r_page < eff);
        o_stat.next_rd     = is_alloc && !found && (r_word != '0);
        o_stat.next_rchk   = is_range;
        o_stat.out_free    = out_free;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_pages     <= bpa_pkg::PAGES_RESET;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
            if (32'(bpa_pkg::PAGES_RESET) > 32'(MAX_PAGES)) begin
                r_count <= CW'(MAX_PAGES);
            end else begin
                r_count <= CW'(bpa_pkg::PAGES_RESET);
            end
        end else begin
            if (i_cfg_valid && i_cfg_index == bpa_pkg::CFG_BASE) begin
                r_base <= i_cfg_data;
            end else if (i_cfg_valid && i_cfg_index == bpa_pkg::CFG_PAGES) begin
                // reinit: drop every word and reload the count
                r_pages     <= i_cfg_data[bpa_pkg::COUNT_W-1:0];
                r_row_valid <= '0;
                r_count     <= cfg_eff;
            end
            if (ram_we) begin
                r_row_valid[ram_waddr] <= 1'b1;
                if (take || is_alloc) begin
                    if (r_count != '0) begin
                        r_count <= r_count - CW'(1);
                    end
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.fin) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mode    <= i_mode;
            r_addr    <= {1'b0, i_address};
            r_end     <= i_end_address;
            r_status  <= bpa_pkg::ST_OK;
            r_granted <= '0;
            r_taken   <= 1'b0;
        end
        if (i_cmd.loc) begin
            r_page <= CW'(addr_off);
            r_word <= top_word;
            if (is_alloc && r_count == '0) begin
                r_status <= bpa_pkg::ST_NOMEM;
            end else if ((is_single || is_range) && !loc_ok) begin
                r_status <= bpa_pkg::ST_OUTSIDE;
            end
        end
        if (i_cmd.rd) begin
            r_rd_word <= ram_raddr;
        end
        if (i_cmd.ex) begin
            if (is_alloc) begin
                if (found) begin
                    r_granted <= r_base + (AW'(found_page) << PAGE_BITS);
                end else if (r_word == '0) begin
                    r_status <= bpa_pkg::ST_NOMEM;
                end else begin
                    r_word <= r_word - WW'(1);
                end
            end else if (is_single) begin
                r_taken <= was;
            end else begin
                r_addr <= r_addr + ((AW + 1)'(1) << PAGE_BITS);
                r_page <= r_page + CW'(1);
            end
        end
        if (i_cmd.fin) begin
            r_o_status  <= r_status;
            r_o_granted <= r_granted;
            r_o_taken   <= r_taken;
            r_o_free    <= bpa_pkg::COUNT_W'(r_count);
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_o_status;
    assign o_granted_address = r_o_granted;
    assign o_page_was_taken  = r_o_taken;
    assign o_free_pages      = r_o_free;
endmodule
